// ===== hdl/t7c_pkg.sv =====
// Shared types, constants and helper functions for the type 7 password codec.
package t7c_pkg;

  localparam int KEY_TABLE_SIZE = 53;
  localparam int KEY_IDX_W      = $clog2(KEY_TABLE_SIZE);
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 4;
  localparam int SEED_W         = 4;
  localparam int OUT_SLOTS      = 4;
  localparam int SLOT_IDX_W     = $clog2(OUT_SLOTS);
  localparam int SLOT_CNT_W     = $clog2(OUT_SLOTS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SEED = CFG_IDX_W'(1);

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic [7:0] KEY_TAB [KEY_TABLE_SIZE] = '{
    8'h64, 8'h73, 8'h66, 8'h64, 8'h3b, 8'h6b, 8'h66, 8'h6f,
    8'h41, 8'h2c, 8'h2e, 8'h69, 8'h79, 8'h65, 8'h77, 8'h72,
    8'h6b, 8'h6c, 8'h64, 8'h4a, 8'h4b, 8'h44, 8'h48, 8'h53,
    8'h55, 8'h42, 8'h73, 8'h67, 8'h76, 8'h63, 8'h61, 8'h36,
    8'h39, 8'h38, 8'h33, 8'h34, 8'h6e, 8'h63, 8'h78, 8'h76,
    8'h39, 8'h38, 8'h37, 8'h33, 8'h32, 8'h35, 8'h34, 8'h6b,
    8'h3b, 8'h66, 8'h67, 8'h38, 8'h37
  };

  typedef enum logic [1:0] {
    ITEM_ENC_SEED = 2'd0,
    ITEM_ENC      = 2'd1,
    ITEM_BYTE     = 2'd2
  } item_kind_t;

  typedef struct packed {
    logic              valid;
    item_kind_t        kind;
    logic [7:0]        opnd;
    logic              use_key;
    logic              last;
    logic              bad;
    logic [SEED_W-1:0] seed;
  } item_t;

  function automatic logic [KEY_IDX_W-1:0] idx_inc(input logic [KEY_IDX_W-1:0] i);
    logic [KEY_IDX_W-1:0] r;
    if (i == KEY_IDX_W'(KEY_TABLE_SIZE - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_lower(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = {4'h3, v};
    end else begin
      r = 8'h57 + {4'h0, v};
    end
    return r;
  endfunction

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b0, 4'(c[3:0] + 4'd9)};
    end else begin
      r = 5'b10000;
    end
    return r;
  endfunction

endpackage

// ===== hdl/type7_password_codec.sv =====
// Top level of the type 7 password codec: streams password or hash text characters.
//
//   Channel  Direction  Handshake               Payload
//   in_      input      in_valid / in_ready     in_char, in_last
//   out_     output     out_valid / out_ready   out_char, out_last, bad_char
//   cfg_     input      cfg_we                  cfg_index, cfg_wdata
//
// Encode makes two output characters per input (four for the first of a string) and is
// bounded by the output port sending one character per cycle while out_ready is high;
// decode takes one per cycle while not stalled; each result waits on the key memory read.
// Reset is synchronous and active low; it returns encode mode, seed 0 and a fresh string.
// A stalled output keeps at most one accepted transaction waiting in the input stage.
module type7_password_codec import t7c_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_char,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char,
  output logic                  out_last,
  output logic                  bad_char
);

  item_t                item;
  logic                 item_take;
  logic                 key_rd_en;
  logic [KEY_IDX_W-1:0] key_rd_addr;
  logic [7:0]           key_q;

  t7c_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char     (in_char),
    .in_last     (in_last),
    .item_o      (item),
    .item_take   (item_take),
    .key_rd_en   (key_rd_en),
    .key_rd_addr (key_rd_addr)
  );

  t7c_key_rom u_key_rom (
    .clk     (clk),
    .rd_en   (key_rd_en),
    .rd_addr (key_rd_addr),
    .rd_data (key_q)
  );

  t7c_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_i    (item),
    .key_q     (key_q),
    .item_take (item_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last),
    .bad_char  (bad_char)
  );

endmodule

// ===== hdl/t7c_key_rom.sv =====
// Synchronous key table memory with a registered read port.
module t7c_key_rom import t7c_pkg::*; (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [KEY_IDX_W-1:0] rd_addr,
  output logic [7:0]           rd_data
);

  logic [7:0] rom_q_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rom_q_r <= KEY_TAB[rd_addr];
    end
  end

  assign rd_data = rom_q_r;

endmodule

// ===== hdl/t7c_parse.sv =====
// Configuration registers, string state and the accepted-transaction stage.
module t7c_parse import t7c_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_char,
  input  logic                  in_last,
  output item_t                 item_o,
  input  logic                  item_take,
  output logic                  key_rd_en,
  output logic [KEY_IDX_W-1:0]  key_rd_addr
);

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_SEED2 = 4'b0010,
    PH_HIGH  = 4'b0100,
    PH_LOW   = 4'b1000
  } phase_t;

  logic                 mode_r;
  logic [SEED_W-1:0]    seed_r;
  logic [KEY_IDX_W-1:0] key_r, key_nxt;
  phase_t               phase_r, phase_nxt;
  logic [3:0]           held_r, held_nxt;
  logic                 pair_r, pair_nxt;
  logic                 failed_r, failed_nxt;
  item_t                item_r, item_nxt;
  logic [KEY_IDX_W-1:0] rd_idx;
  logic                 in_fire;
  logic                 is_dig;
  logic [4:0]           hv;
  logic [6:0]           seed_sum;
  logic                 err;

  assign in_ready = !item_r.valid || item_take;
  assign in_fire  = in_valid && in_ready;
  assign is_dig   = (in_char >= 8'h30) && (in_char <= 8'h39);
  assign hv       = hex_val(in_char);
  assign seed_sum = 7'({3'b000, held_r} * 7'd10) + {3'b000, in_char[3:0]};

  always_comb begin
    key_nxt    = key_r;
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    pair_nxt   = pair_r;
    failed_nxt = failed_r;
    rd_idx     = key_r;
    err        = 1'b0;
    item_nxt   = '0;
    item_nxt.kind = ITEM_BYTE;
    item_nxt.last = in_last;
    item_nxt.seed = seed_r;
    item_nxt.opnd = in_char;
    if (mode_r == MODE_ENC) begin
      item_nxt.valid   = 1'b1;
      item_nxt.use_key = 1'b1;
      if (phase_r == PH_START) begin
        rd_idx        = KEY_IDX_W'(seed_r);
        item_nxt.kind = ITEM_ENC_SEED;
        phase_nxt     = PH_HIGH;
      end else begin
        item_nxt.kind = ITEM_ENC;
      end
      key_nxt = idx_inc(rd_idx);
    end else if (!failed_r) begin
      unique case (phase_r)
        PH_START: begin
          if (!is_dig) begin
            err = 1'b1;
          end else begin
            held_nxt  = in_char[3:0];
            phase_nxt = PH_SEED2;
          end
        end
        PH_SEED2: begin
          if (!is_dig) begin
            err = 1'b1;
          end else begin
            key_nxt   = (seed_sum >= 7'(KEY_TABLE_SIZE)) ?
                        KEY_IDX_W'(seed_sum - 7'(KEY_TABLE_SIZE)) : KEY_IDX_W'(seed_sum);
            phase_nxt = PH_HIGH;
          end
        end
        PH_HIGH: begin
          if (hv[4]) begin
            err = 1'b1;
          end else begin
            held_nxt  = hv[3:0];
            phase_nxt = PH_LOW;
            if (in_last && pair_r) begin
              item_nxt.valid   = 1'b1;
              item_nxt.use_key = 1'b1;
              item_nxt.opnd    = {4'h0, hv[3:0]};
              key_nxt          = idx_inc(key_r);
            end
          end
        end
        PH_LOW: begin
          if (hv[4]) begin
            err = 1'b1;
          end else begin
            item_nxt.valid   = 1'b1;
            item_nxt.use_key = 1'b1;
            item_nxt.opnd    = {held_r, hv[3:0]};
            key_nxt          = idx_inc(key_r);
            pair_nxt         = 1'b1;
            phase_nxt        = PH_HIGH;
          end
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
      if (err) begin
        item_nxt.valid   = 1'b1;
        item_nxt.bad     = 1'b1;
        item_nxt.last    = 1'b1;
        item_nxt.opnd    = 8'h00;
        item_nxt.use_key = 1'b0;
        failed_nxt       = 1'b1;
      end
    end
    if (in_last) begin
      phase_nxt  = PH_START;
      pair_nxt   = 1'b0;
      failed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ENC;
      seed_r   <= '0;
      key_r    <= '0;
      phase_r  <= PH_START;
      held_r   <= '0;
      pair_r   <= 1'b0;
      failed_r <= 1'b0;
      item_r   <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_MODE) begin
        mode_r   <= cfg_wdata[0];
        phase_r  <= PH_START;
        pair_r   <= 1'b0;
        failed_r <= 1'b0;
      end else if (in_fire) begin
        key_r    <= key_nxt;
        phase_r  <= phase_nxt;
        held_r   <= held_nxt;
        pair_r   <= pair_nxt;
        failed_r <= failed_nxt;
      end
      if (cfg_we && cfg_index == REG_SEED) begin
        seed_r <= cfg_wdata[SEED_W-1:0];
      end
      if (in_fire) begin
        item_r <= item_nxt;
      end else if (item_take) begin
        item_r.valid <= 1'b0;
      end
    end
  end

  assign item_o      = item_r;
  assign key_rd_en   = in_fire;
  assign key_rd_addr = rd_idx;

endmodule

// ===== hdl/t7c_emit.sv =====
// Result builder and slot buffer; one character per cycle while out_ready.
module t7c_emit import t7c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  item_t      item_i,
  input  logic [7:0] key_q,
  output logic       item_take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       bad_char
);

  logic [7:0]            slot_char_r [OUT_SLOTS];
  logic                  slot_last_r [OUT_SLOTS];
  logic                  slot_bad_r  [OUT_SLOTS];
  logic [SLOT_CNT_W-1:0] cnt_r;
  logic [SLOT_IDX_W-1:0] head_r;

  logic [7:0]            ld_char [OUT_SLOTS];
  logic                  ld_last [OUT_SLOTS];
  logic                  ld_bad  [OUT_SLOTS];
  logic [SLOT_CNT_W-1:0] ld_cnt;
  logic [7:0]            x;
  logic                  seed_hi;
  logic [3:0]            seed_ones;
  logic                  can_load;
  logic                  out_fire;

  assign x         = item_i.opnd ^ (item_i.use_key ? key_q : 8'h00);
  assign seed_hi   = item_i.seed >= 4'd10;
  assign seed_ones = seed_hi ? 4'(item_i.seed - 4'd10) : item_i.seed;

  always_comb begin
    for (int i = 0; i < OUT_SLOTS; i++) begin
      ld_char[i] = 8'h00;
      ld_last[i] = 1'b0;
      ld_bad[i]  = 1'b0;
    end
    ld_cnt = '0;
    unique case (item_i.kind)
      ITEM_ENC_SEED: begin
        ld_char[0] = {7'b0011000, seed_hi};
        ld_char[1] = {4'h3, seed_ones};
        ld_char[2] = hex_lower(x[7:4]);
        ld_char[3] = hex_lower(x[3:0]);
        ld_last[3] = item_i.last;
        ld_cnt     = SLOT_CNT_W'(4);
      end
      ITEM_ENC: begin
        ld_char[0] = hex_lower(x[7:4]);
        ld_char[1] = hex_lower(x[3:0]);
        ld_last[1] = item_i.last;
        ld_cnt     = SLOT_CNT_W'(2);
      end
      ITEM_BYTE: begin
        ld_char[0] = x;
        ld_last[0] = item_i.last;
        ld_bad[0]  = item_i.bad;
        ld_cnt     = SLOT_CNT_W'(1);
      end
      default: begin
        ld_cnt = '0;
      end
    endcase
  end

  assign out_valid = cnt_r != '0;
  assign out_fire  = out_valid && out_ready;
  assign can_load  = (cnt_r == '0) || (cnt_r == SLOT_CNT_W'(1) && out_ready);
  assign item_take = item_i.valid && can_load;

  assign out_char = slot_char_r[head_r];
  assign out_last = slot_last_r[head_r];
  assign bad_char = slot_bad_r[head_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      head_r <= '0;
    end else if (item_take) begin
      cnt_r  <= ld_cnt;
      head_r <= '0;
    end else if (out_fire) begin
      cnt_r  <= cnt_r - 1'b1;
      head_r <= head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      for (int i = 0; i < OUT_SLOTS; i++) begin
        slot_char_r[i] <= ld_char[i];
        slot_last_r[i] <= ld_last[i];
        slot_bad_r[i]  <= ld_bad[i];
      end
    end
  end

endmodule
